### src/ggnh_pkg.sv
// Package for the greedy geographic next-hop table.
// Holds action and status codes, register indexes and address constants.
package ggnh_pkg;

  typedef enum logic [2:0] {
    ACT_UPDATE  = 3'd0,
    ACT_DELETE  = 3'd1,
    ACT_PREDICT = 3'd2,
    ACT_PURGE   = 3'd3,
    ACT_NEXTHOP = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_NEIGH  = 3'd3,
    ST_NO_CLOSER = 3'd4
  } status_e;

  localparam logic [2:0] REG_LIFETIME = 3'd0;
  localparam logic [2:0] REG_RANGE    = 3'd1;
  localparam logic [2:0] REG_LIMIT_X  = 3'd2;
  localparam logic [2:0] REG_LIMIT_Y  = 3'd3;
  localparam logic [2:0] REG_LIMIT_Z  = 3'd4;
  localparam logic [2:0] REG_BCAST    = 3'd5;

  localparam logic [31:0] AddrLoopback = 32'h7F00_0001;
  localparam logic [31:0] AddrBcast    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] node_addr;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [15:0] time_value;
    logic [15:0] my_x;
    logic [15:0] my_y;
    logic [15:0] my_z;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_hop;
    logic [15:0] pred_x;
    logic [15:0] pred_y;
    logic [15:0] pred_z;
  } rsp_t;

  // One predicted axis: wrap to 16 bits, drop non-positive, clamp to limit.
  function automatic logic [15:0] clamp_axis(logic [15:0] t, logic [15:0] lim);
    logic [15:0] r;
    if (t == 16'd0 || t[15]) r = 16'd0;
    else if (t > lim) r = lim;
    else r = t;
    return r;
  endfunction

endpackage

### src/ggnh_if.sv
// Valid/ready channel carrying one item of a given payload type.
// The payload type is a parameter; the interface itself does not use ggnh_pkg.
interface ggnh_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/greedy_geo_next_hop_table_core.sv
// Top level of the greedy geographic next-hop table.
// Depends on ggnh_pkg and ggnh_if.
//
// Usage: requests enter on req (sink), one result leaves on rsp (source) per
// request. Registers are written over an APB-style port at 4*index.
// Each request runs a scan of the table memory: one read per entry through a
// single predict-and-distance path; each entry passes through the states read,
// multiply, distance and compare. The result register is loaded when the scan
// is through and the output register is free, and a new item is taken only
// after that load. Update and delete locate their key by the same scan and
// write when the result is loaded; predict locates its key the same way.
// The registered memory read port and the shared multiplier path set the
// pace of the scan. Only one item is in work at a time; the result is held
// in an output register, and the next item is taken while it waits, but the
// scan of that item does not load its result until the register is free.
// Reset clears the valid bits (flip-flops), the registers to their defaults
// and all control; the entry memory itself is not cleared. A stalled receiver
// holds the result stable and stops further results.
module greedy_geo_next_hop_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ggnh_if.sink        req,
  ggnh_if.source      rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = IW + 1;

  // ---------------- configuration registers
  logic [15:0] lifetime_q, range_q, lim_x_q, lim_y_q, lim_z_q;
  logic [31:0] bcast_q;
  logic [2:0]  reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= 16'd30;
      range_q    <= 16'd250;
      lim_x_q    <= 16'd1000;
      lim_y_q    <= 16'd1000;
      lim_z_q    <= 16'd300;
      bcast_q    <= 32'h0A01_01FF;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ggnh_pkg::REG_LIFETIME: lifetime_q <= pwdata[15:0];
        ggnh_pkg::REG_RANGE:    range_q    <= pwdata[15:0];
        ggnh_pkg::REG_LIMIT_X:  lim_x_q    <= pwdata[15:0];
        ggnh_pkg::REG_LIMIT_Y:  lim_y_q    <= pwdata[15:0];
        ggnh_pkg::REG_LIMIT_Z:  lim_z_q    <= pwdata[15:0];
        ggnh_pkg::REG_BCAST:    bcast_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ggnh_pkg::REG_LIFETIME: prdata = {16'd0, lifetime_q};
      ggnh_pkg::REG_RANGE:    prdata = {16'd0, range_q};
      ggnh_pkg::REG_LIMIT_X:  prdata = {16'd0, lim_x_q};
      ggnh_pkg::REG_LIMIT_Y:  prdata = {16'd0, lim_y_q};
      ggnh_pkg::REG_LIMIT_Z:  prdata = {16'd0, lim_z_q};
      ggnh_pkg::REG_BCAST:    prdata = bcast_q;
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- entry memory: addr, pos, vel, stamp
  localparam int EW = 32 + 48 + 48 + 16;
  logic [EW-1:0] mem_q [TABLE_DEPTH];
  logic [EW-1:0] rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  // ---------------- control
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIST  = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  ggnh_pkg::req_t req_q;
  logic [CW-1:0] idx_q, idx_d;     // entry being scanned
  logic [IW-1:0] cur_q, cur_d;     // entry whose data is in rd_q
  logic          hit_q, hit_d, free_q, free_d, fnd_q, fnd_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [34:0]   best_q, best_d;
  logic [31:0]   best_addr_q, best_addr_d;
  logic [47:0]   pred_q, pred_d;   // prediction of the hit entry
  logic          out_v_q;
  ggnh_pkg::rsp_t out_q, out_d;
  logic          out_load;

  // entry fields
  logic [31:0] e_addr;
  logic [15:0] e_px, e_py, e_pz, e_vx, e_vy, e_vz, e_st;
  assign {e_addr, e_px, e_py, e_pz, e_vx, e_vy, e_vz, e_st} = rd_q;

  // stage 1: products d*v, low 16 bits; position plus product registered
  logic [15:0] delta;
  logic [15:0] px_q, py_q, pz_q;
  logic [15:0] prod_x, prod_y, prod_z;
  assign delta  = req_q.time_value - e_st;
  assign prod_x = 16'(delta * e_vx);
  assign prod_y = 16'(delta * e_vy);
  assign prod_z = 16'(delta * e_vz);
  logic [15:0] cx, cy, cz;       // clamped prediction from registered sums
  logic [15:0] sx_q, sy_q, sz_q;
  logic [31:0] ea_q;
  logic        ev_q, ok_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      sx_q <= e_px + prod_x;
      sy_q <= e_py + prod_y;
      sz_q <= e_pz + prod_z;
      ea_q <= e_addr;
      ev_q <= valid_q[cur_q];
      ok_q <= (e_addr != ggnh_pkg::AddrLoopback) && (e_addr != ggnh_pkg::AddrBcast)
              && (e_addr != bcast_q);
    end
  end
  assign cx = ggnh_pkg::clamp_axis(sx_q, lim_x_q);
  assign cy = ggnh_pkg::clamp_axis(sy_q, lim_y_q);
  assign cz = ggnh_pkg::clamp_axis(sz_q, lim_z_q);

  // stage 2: squared distances to me and to destination
  function automatic logic [31:0] sq(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction
  logic [34:0] dm_q, dd_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIST) begin
      px_q <= cx; py_q <= cy; pz_q <= cz;
      dm_q <= 35'(sq(cx, req_q.my_x)) + 35'(sq(cy, req_q.my_y))
              + 35'(sq(cz, req_q.my_z));
      dd_q <= 35'(sq(cx, req_q.pos_x)) + 35'(sq(cy, req_q.pos_y))
              + 35'(sq(cz, req_q.pos_z));
    end
  end
  logic [34:0] range2, self_d;
  assign range2 = {3'd0, 32'(range_q) * 32'(range_q)};
  assign self_d = 35'(sq(req_q.pos_x, req_q.my_x)) + 35'(sq(req_q.pos_y, req_q.my_y))
                  + 35'(sq(req_q.pos_z, req_q.my_z));
  logic [16:0] expire;
  assign expire = {1'b0, lifetime_q} + {1'b0, e_st};

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = out_v_q;
  assign rsp.payload = out_q;
  assign out_load  = (state_q == S_DONE) && (!out_v_q || rsp.ready);

  always_comb begin
    state_d = state_q; idx_d = idx_q; cur_d = cur_q;
    hit_d = hit_q; free_d = free_q; fnd_d = fnd_q;
    hit_idx_d = hit_idx_q; free_idx_d = free_idx_q;
    best_d = best_q; best_addr_d = best_addr_q;
    pred_d = pred_q;
    valid_d = valid_q; out_d = out_q;
    mem_we = 1'b0; mem_wa = hit_idx_q;
    mem_wd = {req_q.node_addr, req_q.pos_x, req_q.pos_y, req_q.pos_z,
              req_q.vel_x, req_q.vel_y, req_q.vel_z, req_q.time_value};
    mem_ra = idx_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          state_d = S_READ; idx_d = '0;
          hit_d = 1'b0; free_d = 1'b0; fnd_d = 1'b0;
          best_d = '0; best_addr_d = '0;
        end
      end
      S_READ: begin
        // memory read issued this cycle for idx
        cur_d = idx_q[IW-1:0];
        idx_d = idx_q + CW'(1);
        state_d = S_MUL;
      end
      S_MUL: begin
        // key match, free slot and purge on raw entry
        if (!valid_q[cur_q] && !free_d) begin
          free_d = 1'b1; free_idx_d = cur_q;
        end
        if (valid_q[cur_q] && e_addr == req_q.node_addr && !hit_q) begin
          hit_d = 1'b1; hit_idx_d = cur_q;
        end
        if (req_q.action == ggnh_pkg::ACT_PURGE && valid_q[cur_q]
            && expire <= {1'b0, req_q.time_value})
          valid_d[cur_q] = 1'b0;
        state_d = S_DIST;
      end
      S_DIST: state_d = S_EVAL;
      S_EVAL: begin
        if (ev_q && ok_q && dm_q <= range2 &&
            (!fnd_q || dd_q < best_q || (dd_q == best_q && ea_q < best_addr_q))) begin
          fnd_d = 1'b1; best_d = dd_q; best_addr_d = ea_q;
        end
        // keep the hit entry's prediction apart from the held result
        if (hit_q && hit_idx_q == cur_q) pred_d = {px_q, py_q, pz_q};
        state_d = (idx_q == CW'(TABLE_DEPTH)) ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
          out_d.status = ggnh_pkg::ST_OK;
          out_d.next_hop = '0;
          if (req_q.action == ggnh_pkg::ACT_PREDICT && hit_q)
            {out_d.pred_x, out_d.pred_y, out_d.pred_z} = pred_q;
          else begin
            out_d.pred_x = '0; out_d.pred_y = '0; out_d.pred_z = '0;
          end
          case (req_q.action)
            ggnh_pkg::ACT_UPDATE: begin
              if (hit_q || free_q) begin
                mem_we = 1'b1;
                mem_wa = hit_q ? hit_idx_q : free_idx_q;
                valid_d[mem_wa] = 1'b1;
              end else out_d.status = ggnh_pkg::ST_FULL;
            end
            ggnh_pkg::ACT_DELETE: begin
              if (hit_q) valid_d[hit_idx_q] = 1'b0;
              else out_d.status = ggnh_pkg::ST_NOT_FOUND;
            end
            ggnh_pkg::ACT_PREDICT: begin
              if (!hit_q) out_d.status = ggnh_pkg::ST_NOT_FOUND;
            end
            ggnh_pkg::ACT_NEXTHOP: begin
              if (!fnd_q) out_d.status = ggnh_pkg::ST_NO_NEIGH;
              else if (self_d > best_q) out_d.next_hop = best_addr_q;
              else out_d.status = ggnh_pkg::ST_NO_CLOSER;
            end
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      out_v_q <= 1'b0;
      idx_q <= '0; cur_q <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; fnd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      idx_q <= idx_d; cur_q <= cur_d;
      hit_q <= hit_d; free_q <= free_d; fnd_q <= fnd_d;
      if (out_load) out_v_q <= 1'b1;
      else if (rsp.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid) req_q <= req.payload;
    hit_idx_q <= hit_idx_d; free_idx_q <= free_idx_d;
    best_q <= best_d; best_addr_q <= best_addr_d;
    pred_q <= pred_d;
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == S_IDLE) else $error("ready outside idle");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_v_q || rsp.ready)) else $error("result overwritten");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CW'(TABLE_DEPTH)) else $error("scan index past depth");
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> $stable(rsp.payload)) else $error("result changed");
`endif

endmodule
